// ----- rtl/base58_decoder_unit_macros.svh -----
// Assertion macros shared by the checker files of the base58 decoder unit.
// Depends on nothing; each file that asserts includes this header.
`ifndef BASE58_DECODER_UNIT_MACROS_SVH
`define BASE58_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B58D_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define B58D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/b58d_pkg.sv -----
// Package of the base58 decoder unit: constants, command and status types,
// and the alphabet lookup. Depends on nothing.
package b58d_pkg;

  localparam int B58D_MAX_BYTES = 48;

  localparam logic [7:0] CHAR_ONE = 8'h31;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CHAR = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } digit_t;

  typedef struct packed {
    logic accept;
    logic mul_step;
    logic extend;
    logic report;
    logic start_emit;
    logic zero_step;
    logic acc_step;
  } dp_cmd_t;

  typedef struct packed {
    logic err_any;
    logic digit_ok;
    logic used_zero;
    logic mul_done;
    logic empty;
    logic have_zeros;
    logic zero_last;
    logic acc_last;
  } dp_sts_t;

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t d;
    d.valid = 1'b1;
    case (c) inside
      [8'h31:8'h39]: d.value = 6'(c - 8'h31);
      [8'h41:8'h48]: d.value = 6'(c - 8'h41 + 8'd9);
      [8'h4a:8'h4e]: d.value = 6'(c - 8'h4a + 8'd17);
      [8'h50:8'h5a]: d.value = 6'(c - 8'h50 + 8'd22);
      [8'h61:8'h6b]: d.value = 6'(c - 8'h61 + 8'd33);
      [8'h6d:8'h7a]: d.value = 6'(c - 8'h6d + 8'd44);
      default: begin
        d.valid = 1'b0;
        d.value = '0;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/b58d_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module b58d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/b58d_ctrl.sv -----
// Controller of the base58 decoder unit: sequences accept, multiply pass,
// extension and output. Depends on b58d_pkg.
module b58d_ctrl import b58d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    end_of_text,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_EXT   = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_seen;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.err_any || !sts.digit_ok) begin
            state_next = end_of_text ? S_SETUP : S_IDLE;
          end else begin
            state_next = sts.used_zero ? S_EXT : S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_next = S_EXT;
        end
      end
      S_EXT: begin
        cmd.extend = 1'b1;
        state_next = last_seen ? S_SETUP : S_IDLE;
      end
      S_SETUP: begin
        if (sts.err_any || sts.empty) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.start_emit = 1'b1;
          state_next = sts.have_zeros ? S_ZERO : S_ACC;
        end
      end
      S_ZERO: begin
        cmd.zero_step = 1'b1;
        if (sts.zero_last) begin
          state_next = sts.used_zero ? S_IDLE : S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        last_seen <= end_of_text;
      end
    end
  end

endmodule

// ----- rtl/b58d_datapath.sv -----
// Datapath of the base58 decoder unit: byte accumulator RAM, multiply-by-58
// unit, counters, error latch and result register. Depends on b58d_pkg, b58d_ram.
module b58d_datapath import b58d_pkg::*; #(
  parameter int MAX_BYTES = B58D_MAX_BYTES,
  localparam int AW = $clog2(MAX_BYTES),
  localparam int LW = $clog2(MAX_BYTES + 1),
  localparam int ZW = $clog2(MAX_BYTES + 2)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       result_valid,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       final_item,
  output logic [1:0] status
);

  digit_t        dig;
  logic [LW-1:0] used_length;
  logic [ZW-1:0] leading_ones;
  logic          still_leading;
  logic [1:0]    error_code;
  logic [5:0]    carry;
  logic [AW-1:0] idx;

  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          we;

  logic [13:0]   prod;
  logic [LW-1:0] used_m1;
  logic          grow;
  logic [LW-1:0] new_len;
  logic [ZW:0]   total_new;
  logic [ZW:0]   total_now;
  logic          overflow;
  logic          final_zero;
  logic          clear;

  assign dig        = digit_of(char_code);
  assign prod       = {6'd0, rd_data} * 14'd58 + {8'd0, carry};
  assign used_m1    = used_length - LW'(1);
  assign grow       = (carry != 6'd0) && (used_length < LW'(MAX_BYTES));
  assign new_len    = used_length + LW'(grow);
  assign total_new  = (ZW + 1)'(leading_ones) + (ZW + 1)'(new_len);
  assign total_now  = (ZW + 1)'(leading_ones) + (ZW + 1)'(used_length);
  assign overflow   = ((carry != 6'd0) && !grow) || (total_new > (ZW + 1)'(MAX_BYTES));
  assign final_zero = sts.zero_last && sts.used_zero;

  assign sts.err_any    = (error_code != ST_OK);
  assign sts.digit_ok   = dig.valid;
  assign sts.used_zero  = (used_length == '0);
  assign sts.mul_done   = (LW'(idx) == used_m1);
  assign sts.empty      = (total_now == '0);
  assign sts.have_zeros = (leading_ones != '0);
  assign sts.zero_last  = (leading_ones == ZW'(1));
  assign sts.acc_last   = (idx == '0);

  assign clear = cmd.report || (cmd.zero_step && final_zero) ||
                 (cmd.acc_step && sts.acc_last);

  always_comb begin
    if (cmd.accept) begin
      rd_addr = '0;
    end else if (cmd.mul_step) begin
      rd_addr = idx + AW'(1);
    end else if (cmd.acc_step) begin
      rd_addr = idx - AW'(1);
    end else begin
      rd_addr = used_m1[AW-1:0];
    end
  end

  assign we      = cmd.mul_step || (cmd.extend && grow);
  assign wr_addr = cmd.mul_step ? idx : used_length[AW-1:0];
  assign wr_data = cmd.mul_step ? prod[7:0] : {2'd0, carry};

  b58d_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length   <= '0;
      leading_ones  <= '0;
      still_leading <= 1'b1;
      error_code    <= ST_OK;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= cmd.report || cmd.zero_step || cmd.acc_step;
      if (cmd.accept && (error_code == ST_OK)) begin
        if (!dig.valid) begin
          error_code <= ST_CHAR;
        end else if (still_leading && (char_code == CHAR_ONE)) begin
          leading_ones <= leading_ones + ZW'(1);
        end else begin
          still_leading <= 1'b0;
        end
      end
      if (cmd.extend) begin
        used_length <= new_len;
        if (overflow) begin
          error_code <= ST_LEN;
        end
      end
      if (cmd.zero_step) begin
        leading_ones <= leading_ones - ZW'(1);
      end
      if (clear) begin
        used_length   <= '0;
        leading_ones  <= '0;
        still_leading <= 1'b1;
        error_code    <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      carry <= dig.value;
      idx   <= '0;
    end else if (cmd.mul_step) begin
      carry <= prod[13:8];
      idx   <= idx + AW'(1);
    end else if (cmd.start_emit) begin
      idx <= used_m1[AW-1:0];
    end else if (cmd.acc_step) begin
      idx <= idx - AW'(1);
    end
    if (cmd.report) begin
      data_byte  <= 8'd0;
      byte_valid <= 1'b0;
      final_item <= 1'b1;
      status     <= error_code;
    end else if (cmd.zero_step) begin
      data_byte  <= 8'd0;
      byte_valid <= 1'b1;
      final_item <= final_zero;
      status     <= ST_OK;
    end else if (cmd.acc_step) begin
      data_byte  <= rd_data;
      byte_valid <= 1'b1;
      final_item <= sts.acc_last;
      status     <= ST_OK;
    end
  end

endmodule

// ----- rtl/base58_decoder_unit.sv -----
// Top level of the base58 decoder unit (Bitcoin alphabet).
// Depends on b58d_pkg, b58d_ctrl and b58d_datapath.
//
// Channel   Handshake              Payload
// input     start / busy           char_code, end_of_text
// result    result_valid (strobe)  data_byte, byte_valid, final_item, status
//
// A valid character is accepted, then each accumulator byte passes in turn through the
// single multiply-by-58 unit and RAM port pair, and finally the accumulator
// is extended. An invalid character, or any character after an error, is
// only accepted. The last item adds a set-up step, then the result bytes one
// after another; an error report is issued from the set-up step.
// Reset is synchronous; the accumulator needs no clearing since only bytes
// below the fill count are read. Results cannot be stalled.
module base58_decoder_unit import b58d_pkg::*; #(
  parameter int MAX_BYTES = B58D_MAX_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       result_valid,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic       final_item,
  output logic [1:0] status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  b58d_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .end_of_text (end_of_text),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  b58d_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .final_item   (final_item),
    .status       (status)
  );

endmodule

// ----- rtl/b58d_checker.sv -----
// Port-level checks of the base58 decoder unit and their bind to the top level.
// Depends on b58d_pkg, base58_decoder_unit_macros.svh and base58_decoder_unit.
`include "base58_decoder_unit_macros.svh"

module b58d_checker import b58d_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       end_of_text,
  input logic       result_valid,
  input logic       byte_valid,
  input logic       final_item,
  input logic [1:0] status
);

  // A decoded byte is never reported together with an error.
  `B58D_ASSERT_NOW(a_byte_ok, clk, rst, result_valid && byte_valid, status == ST_OK)
  // An item without a byte is always the only and final item of its string.
  `B58D_ASSERT_NOW(a_nobyte_final, clk, rst, result_valid && !byte_valid, final_item)
  // The bytes of one string come in an unbroken burst.
  `B58D_ASSERT_NEXT(a_burst, clk, rst, result_valid && !final_item, result_valid)
  // A character that is not the last produces no result.
  `B58D_ASSERT_NEXT(a_quiet, clk, rst, start && !busy && !end_of_text, !result_valid)
  // Strings are separated by a gap: no result directly follows a final item.
  `B58D_ASSERT_NEXT(a_gap, clk, rst, result_valid && final_item, !result_valid)

endmodule

bind base58_decoder_unit b58d_checker u_b58d_checker (.*);

// ----- bench/tb_base58_decoder_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for base58_decoder_unit: Base58 strings go in one character
// per item, and each decoded byte or error report is checked against a predictor.
// Depends on b58d_pkg and the base58_decoder_unit RTL.
module tb_base58_decoder_unit;
  import b58d_pkg::*;

  localparam int MAX_BYTES   = B58D_MAX_BYTES;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 155;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       fin;
    logic [1:0] st;
  } decoded_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] char_code = 8'h00;
  logic       end_of_text = 1'b0;
  logic       result_valid;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       final_item;
  logic [1:0] status;

  string         b58_symbols = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  logic [7:0]    acc_bytes [MAX_BYTES];
  int            acc_len;
  int            zero_run;
  bit            in_zero_run;
  logic [1:0]    latched_status;
  decoded_byte_t pending_bytes [$];
  logic [7:0]    text_buf [$];

  bit idle_on = 1'b1;
  int error_count = 0;
  int cycle_count = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int error_strings = 0;
  int bytes_checked = 0;

  base58_decoder_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .char_code(char_code),
    .end_of_text(end_of_text),
    .result_valid(result_valid),
    .data_byte(data_byte),
    .byte_valid(byte_valid),
    .final_item(final_item),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_base58_decoder_unit: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: mismatch on %s, got %0h, expected %0h", $time, field, got, want);
    error_count++;
  endtask

  task automatic add_char(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic add_expected(input decoded_byte_t b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  function automatic int symbol_value(input logic [7:0] c);
    for (int i = 0; i < 58; i++) begin
      if (b58_symbols[i] == c) return i;
    end
    return -1;
  endfunction

  task automatic clear_decoder_state();
    foreach (acc_bytes[i]) acc_bytes[i] = 8'h00;
    acc_len = 0;
    zero_run = 0;
    in_zero_run = 1'b1;
    latched_status = ST_OK;
  endtask

  task automatic absorb_symbol(input logic [7:0] c);
    int digit;
    int carry;
    if (latched_status != ST_OK) return;
    digit = symbol_value(c);
    if (digit < 0) begin
      latched_status = ST_CHAR;
      return;
    end
    if (in_zero_run && c == CHAR_ONE) zero_run++;
    else in_zero_run = 1'b0;
    carry = digit;
    for (int i = 0; i < acc_len; i++) begin
      carry += acc_bytes[i] * 58;
      acc_bytes[i] = 8'(carry);
      carry = carry >> 8;
    end
    while (carry != 0) begin
      if (acc_len >= MAX_BYTES) begin
        latched_status = ST_LEN;
        return;
      end
      acc_bytes[acc_len] = 8'(carry);
      acc_len++;
      carry = carry >> 8;
    end
    if (zero_run + acc_len > MAX_BYTES) latched_status = ST_LEN;
  endtask

  task automatic predict_decode(input logic [7:0] c, input logic last);
    decoded_byte_t b;
    absorb_symbol(c);
    if (!last) return;
    b = '{data: 8'h00, valid: 1'b0, fin: 1'b1, st: latched_status};
    if (latched_status != ST_OK) begin
      error_strings++;
      add_expected(b);
    end else if (zero_run + acc_len == 0) begin
      add_expected(b);
    end else begin
      b.valid = 1'b1;
      b.fin = 1'b0;
      for (int i = 0; i < zero_run; i++) add_expected(b);
      for (int i = acc_len - 1; i >= 0; i--) begin
        b.data = acc_bytes[i];
        add_expected(b);
      end
      pending_bytes[pending_bytes.size() - 1].fin = 1'b1;
    end
    clear_decoder_state();
  endtask

  always @(posedge clk) begin
    decoded_byte_t want;
    if (!rst && result_valid) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected result", data_byte, 0);
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (data_byte !== want.data) report_mismatch("data_byte", data_byte, want.data);
        if (byte_valid !== want.valid) report_mismatch("byte_valid", byte_valid, want.valid);
        if (final_item !== want.fin) report_mismatch("final_item", final_item, want.fin);
        if (status !== want.st) report_mismatch("status", status, want.st);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    if (idle_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    char_code <= c;
    end_of_text <= last;
    do @(posedge clk); while (busy);
    chars_sent++;
    predict_decode(c, last);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    strings_sent++;
    text_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic load_repeat(input logic [7:0] c, input int n);
    repeat (n) add_char(c);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic test_known_strings();
    load_text("1");    send_text();
    load_text("z");    send_text();
    load_text("111z"); send_text();
    load_text("2111"); send_text();
    load_text("5Hue"); send_text();
  endtask

  task automatic test_bad_chars();
    load_text("0"); send_text();
    load_text("2"); add_char(8'h00); load_text("3"); send_text();
    add_char(8'hff); send_text();
    add_char(8'h80); send_text();
    load_text("IOl"); send_text();
  endtask

  task automatic test_capacity();
    load_repeat(CHAR_ONE, MAX_BYTES); send_text();
    load_repeat(CHAR_ONE, MAX_BYTES + 1); load_text("0"); send_text();
    load_repeat("z", 65); send_text();
    load_repeat("z", 66); send_text();
  endtask

  task automatic test_random_strings();
    int first_char;
    int kind;
    int n;
    first_char = chars_sent;
    while (chars_sent - first_char < RANDOM_ITEMS) begin
      idle_on = !(strings_sent % 40 >= 10 && strings_sent % 40 < 20);
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        if ($urandom_range(0, 2) == 0) load_repeat(CHAR_ONE, $urandom_range(1, 3));
        n = $urandom_range(1, 12);
        repeat (n) add_char(b58_symbols[$urandom_range(0, 57)]);
      end else if (kind < 90) begin
        n = $urandom_range(20, 66);
        repeat (n) add_char(b58_symbols[$urandom_range(0, 57)]);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) add_char(8'($urandom_range(0, 255)));
      end
      send_text();
      if ($urandom_range(0, 24) == 0) drain_results();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clear_decoder_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_known_strings();
    test_bad_chars();
    drain_results();
    test_capacity();
    drain_results();
    test_random_strings();
    drain_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d strings in %0d characters, %0d of them ending in an error report.",
             strings_sent, chars_sent, error_strings);
    $display("Checked %0d result items, %0d mismatches.", bytes_checked, error_count);
    if (error_count == 0 && pending_bytes.size() == 0) begin
      $display("tb_base58_decoder_unit: clean");
    end else begin
      $display("tb_base58_decoder_unit: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/b58d_pkg.sv
rtl/b58d_ram.sv
rtl/b58d_ctrl.sv
rtl/b58d_datapath.sv
rtl/base58_decoder_unit.sv
rtl/b58d_checker.sv
bench/tb_base58_decoder_unit.sv
